// ===== hdl/pspa_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the slot pool allocator
// no dependencies
package pspa_pkg;

  localparam int POOL_SLOTS_DEF = 512;

  localparam int MODE_W     = 3;
  localparam int CLIENT_W   = 7;
  localparam int OWNER_W    = 6;
  localparam int TIME_W     = 32;
  localparam int LIFE_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 9;
  localparam int COUNT_W    = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_ALLOC         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC_NOMODEL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HIGH          = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ATTACH        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_KILL          = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MODEL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CLIENT = 2'd3;

  localparam logic REG_LIFETIME   = 1'b0;
  localparam logic REG_MAX_CLIENT = 1'b1;

  localparam logic [LIFE_W-1:0]  LIFETIME_RST   = 16'd750;
  localparam logic [OWNER_W-1:0] MAX_CLIENT_RST = 6'd32;
  localparam logic [COUNT_W-1:0] KILL_MAX       = 10'd1023;

  typedef struct packed {
    logic               high;
    logic               attached;
    logic               modelless;
    logic [OWNER_W-1:0] owner;
  } meta_t;

  typedef struct packed {
    logic                capture;
    logic                alloc;
    logic                walk_start;
    logic                walk_step;
    logic                fail;
    logic [STATUS_W-1:0] fail_code;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              model;
    logic              client_ok;
    logic              free_avail;
    logic              active_empty;
    logic              walk_hit;
    logic              walk_last;
    logic              out_free;
  } stat_t;

endpackage

// ===== hdl/pspa_regs.sv =====
// configuration registers behind the apb-style port
// depends on pspa_pkg
module pspa_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pspa_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [pspa_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [pspa_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output logic [pspa_pkg::LIFE_W-1:0]          default_lifetime,
  output logic [pspa_pkg::OWNER_W-1:0]         max_client
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_lifetime <= pspa_pkg::LIFETIME_RST;
      max_client       <= pspa_pkg::MAX_CLIENT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        pspa_pkg::REG_LIFETIME:   default_lifetime <= pwdata[pspa_pkg::LIFE_W-1:0];
        pspa_pkg::REG_MAX_CLIENT: max_client       <= pwdata[pspa_pkg::OWNER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pspa_pkg::REG_LIFETIME:   prdata = pspa_pkg::CFG_DATA_W'(default_lifetime);
      pspa_pkg::REG_MAX_CLIENT: prdata = pspa_pkg::CFG_DATA_W'(max_client);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== hdl/pspa_ctrl.sv =====
// controller state machine: request decode, list walk sequencing, result hand-off
// depends on pspa_pkg
module pspa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  pspa_pkg::stat_t stat,
  output pspa_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {IDLE, EXEC, WALK, DONE} state_t;

  state_t state;

  assign req_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: if (req_valid) state <= EXEC;
        EXEC: state <= cmd.walk_start ? WALK : DONE;
        WALK: if (stat.walk_hit || stat.walk_last) state <= DONE;
        DONE: if (stat.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    case (state)
      IDLE: cmd.capture = req_valid;
      EXEC: begin
        case (stat.mode)
          pspa_pkg::MODE_ALLOC, pspa_pkg::MODE_ALLOC_NOMODEL: begin
            if (!stat.free_avail) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = pspa_pkg::ST_EXHAUSTED;
            end else if (stat.mode == pspa_pkg::MODE_ALLOC && !stat.model) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = pspa_pkg::ST_NO_MODEL;
            end else begin
              cmd.alloc = 1'b1;
            end
          end
          pspa_pkg::MODE_HIGH, pspa_pkg::MODE_ATTACH: begin
            if (stat.mode == pspa_pkg::MODE_ATTACH && !stat.client_ok) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = pspa_pkg::ST_BAD_CLIENT;
            end else if (!stat.model) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = pspa_pkg::ST_NO_MODEL;
            end else if (stat.free_avail) begin
              cmd.alloc = 1'b1;
            end else if (stat.active_empty) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = pspa_pkg::ST_EXHAUSTED;
            end else begin
              cmd.walk_start = 1'b1;
            end
          end
          pspa_pkg::MODE_KILL: begin
            if (!stat.client_ok) begin
              cmd.fail      = 1'b1;
              cmd.fail_code = pspa_pkg::ST_BAD_CLIENT;
            end else if (!stat.active_empty) begin
              cmd.walk_start = 1'b1;
            end
          end
          default: ;
        endcase
      end
      WALK: begin
        cmd.walk_step = 1'b1;
        // a reuse walk that reaches the end of the list found nothing
        if (!stat.walk_hit && stat.walk_last && stat.mode != pspa_pkg::MODE_KILL) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = pspa_pkg::ST_EXHAUSTED;
        end
      end
      DONE: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hdl/pspa_dp.sv =====
// datapath: slot stores, list heads, fill counter, walk cursor, result and output registers
// depends on pspa_pkg
module pspa_dp #(
  parameter int POOL_SLOTS = pspa_pkg::POOL_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [pspa_pkg::MODE_W-1:0]        mode,
  input  logic                               model_present,
  input  logic signed [pspa_pkg::CLIENT_W-1:0] client_id,
  input  logic [pspa_pkg::TIME_W-1:0]        now_time,
  input  logic [pspa_pkg::LIFE_W-1:0]        life_time,
  input  logic [pspa_pkg::LIFE_W-1:0]        default_lifetime,
  input  logic [pspa_pkg::OWNER_W-1:0]       max_client,
  input  pspa_pkg::cmd_t                     cmd,
  output pspa_pkg::stat_t                    stat,
  output logic [pspa_pkg::STATUS_W-1:0]      status,
  output logic [pspa_pkg::SLOT_W-1:0]        slot,
  output logic                               reused,
  output logic [pspa_pkg::COUNT_W-1:0]       killed_count,
  output logic                               rsp_valid,
  input  logic                               rsp_ready
);

  localparam int SW    = $clog2(POOL_SLOTS);
  localparam int LW    = $clog2(POOL_SLOTS + 1);
  localparam int SlotW = pspa_pkg::SLOT_W;
  localparam int TimeW = pspa_pkg::TIME_W;
  localparam logic [LW-1:0] NullSlot = LW'(POOL_SLOTS);

  logic [pspa_pkg::MODE_W-1:0]   in_mode;
  logic                          in_model;
  logic [pspa_pkg::CLIENT_W-1:0] in_client;
  logic [TimeW-1:0]              in_now;
  logic [pspa_pkg::LIFE_W-1:0]   in_life;

  logic [LW-1:0] fill;
  logic [LW-1:0] active_head;
  logic [LW-1:0] cur;
  logic [LW-1:0] rd_link;
  pspa_pkg::meta_t rd_meta;

  logic [pspa_pkg::STATUS_W-1:0] res_status;
  logic [SlotW-1:0]              res_slot;
  logic                          res_reused;
  logic [pspa_pkg::COUNT_W-1:0]  res_count;

  logic [LW-1:0]    link_mem [POOL_SLOTS];
  pspa_pkg::meta_t  meta_mem [POOL_SLOTS];
  logic [TimeW-1:0] exp_mem  [POOL_SLOTS];

  logic            is_high, is_attach, is_nomodel, is_kill;
  logic            client_ok, kill_match, reuse_hit, kill_hit;
  logic            meta_we, exp_we;
  logic [LW-1:0]   raddr;
  logic [SW-1:0]   wr_addr;
  logic [pspa_pkg::LIFE_W-1:0] life_sel;
  logic [TimeW-1:0] new_expiry, exp_wdata;
  pspa_pkg::meta_t new_meta;

  always_comb begin
    is_high    = (in_mode == pspa_pkg::MODE_HIGH) || (in_mode == pspa_pkg::MODE_ATTACH);
    is_attach  = (in_mode == pspa_pkg::MODE_ATTACH);
    is_nomodel = (in_mode == pspa_pkg::MODE_ALLOC_NOMODEL);
    is_kill    = (in_mode == pspa_pkg::MODE_KILL);
    client_ok  = !in_client[pspa_pkg::CLIENT_W-1] &&
                 (in_client[pspa_pkg::OWNER_W-1:0] <= max_client);
    life_sel   = is_attach ? in_life : default_lifetime;
    new_expiry = in_now + TimeW'(life_sel);
    new_meta.high      = is_high;
    new_meta.attached  = is_attach;
    new_meta.modelless = is_nomodel;
    new_meta.owner     = in_client[pspa_pkg::OWNER_W-1:0];
    kill_match = rd_meta.attached && (rd_meta.owner == in_client[pspa_pkg::OWNER_W-1:0]);
    reuse_hit  = !is_kill && !rd_meta.high;
    kill_hit   = cmd.walk_step && is_kill && kill_match;
    raddr      = cmd.walk_start ? active_head : rd_link;
    wr_addr    = cmd.alloc ? fill[SW-1:0] : cur[SW-1:0];
    meta_we    = cmd.alloc || (cmd.walk_step && reuse_hit);
    exp_we     = meta_we || kill_hit;
    exp_wdata  = is_kill ? in_now : new_expiry;
  end

  always_comb begin
    stat.mode         = in_mode;
    stat.model        = in_model;
    stat.client_ok    = client_ok;
    stat.free_avail   = (fill != NullSlot);
    stat.active_empty = (active_head == NullSlot);
    stat.walk_hit     = reuse_hit;
    stat.walk_last    = (rd_link == NullSlot);
    stat.out_free     = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) link_mem[wr_addr] <= active_head;
    if (meta_we)   meta_mem[wr_addr] <= new_meta;
    if (exp_we)    exp_mem[wr_addr]  <= exp_wdata;
    rd_link <= link_mem[raddr[SW-1:0]];
    rd_meta <= meta_mem[raddr[SW-1:0]];
  end

  // free list is popped in index order only, so its head doubles as a fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      active_head <= NullSlot;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        fill        <= fill + LW'(1);
        active_head <= fill;
      end
      if (cmd.out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_mode    <= mode;
      in_model   <= model_present;
      in_client  <= client_id;
      in_now     <= now_time;
      in_life    <= life_time;
      res_status <= pspa_pkg::ST_OK;
      res_slot   <= '0;
      res_reused <= 1'b0;
      res_count  <= '0;
    end
    if (cmd.walk_start) cur <= active_head;
    else if (cmd.walk_step) cur <= rd_link;
    if (cmd.fail) res_status <= cmd.fail_code;
    if (cmd.alloc) res_slot <= SlotW'(fill);
    if (cmd.walk_step && reuse_hit) begin
      res_slot   <= SlotW'(cur);
      res_reused <= 1'b1;
    end
    if (kill_hit && res_count != pspa_pkg::KILL_MAX) begin
      res_count <= res_count + pspa_pkg::COUNT_W'(1);
    end
    if (cmd.out_load) begin
      status       <= res_status;
      slot         <= res_slot;
      reused       <= res_reused;
      killed_count <= res_count;
    end
  end

endmodule

// ===== hdl/priority_slot_pool_allocator.sv =====
// Slot pool allocator with priority reuse: top level joining registers, controller, datapath.
// Allocate, and requests that fail at decode, answer without a list walk; reuse and kill walk
// the active list one slot per cycle, up to the list length (<= POOL_SLOTS).
// One request at a time: a new request is taken only after the last response is loaded.
// Reset (rst, synchronous): all slots free at once via the fill count, no clearing pass;
// registers return to lifetime 750 ms and max client 32.
module priority_slot_pool_allocator #(
  parameter int POOL_SLOTS = pspa_pkg::POOL_SLOTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  logic [pspa_pkg::MODE_W-1:0]            mode,
  input  logic                                   model_present,
  input  logic signed [pspa_pkg::CLIENT_W-1:0]   client_id,
  input  logic [pspa_pkg::TIME_W-1:0]            now_time,
  input  logic [pspa_pkg::LIFE_W-1:0]            life_time,
  output logic                                   rsp_valid,
  input  logic                                   rsp_ready,
  output logic [pspa_pkg::STATUS_W-1:0]          status,
  output logic [pspa_pkg::SLOT_W-1:0]            slot,
  output logic                                   reused,
  output logic [pspa_pkg::COUNT_W-1:0]           killed_count,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [pspa_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [pspa_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [pspa_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  logic [pspa_pkg::LIFE_W-1:0]  default_lifetime;
  logic [pspa_pkg::OWNER_W-1:0] max_client;
  pspa_pkg::cmd_t  cmd;
  pspa_pkg::stat_t stat;

  pspa_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .default_lifetime (default_lifetime),
    .max_client       (max_client)
  );

  pspa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pspa_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .mode             (mode),
    .model_present    (model_present),
    .client_id        (client_id),
    .now_time         (now_time),
    .life_time        (life_time),
    .default_lifetime (default_lifetime),
    .max_client       (max_client),
    .cmd              (cmd),
    .stat             (stat),
    .status           (status),
    .slot             (slot),
    .reused           (reused),
    .killed_count     (killed_count),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready)
  );

endmodule

// ===== hdl/pspa_checker.sv =====
// port-level checks for the slot pool allocator, bound to the top level
// depends on pspa_pkg and priority_slot_pool_allocator
module pspa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [pspa_pkg::STATUS_W-1:0] status,
  input logic [pspa_pkg::SLOT_W-1:0]   slot,
  input logic                          reused,
  input logic [pspa_pkg::COUNT_W-1:0]  killed_count
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("response pending or request blocked after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({status, slot, reused, killed_count}))
    else $error("stalled response changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in progress");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != pspa_pkg::ST_OK |-> slot == '0 && !reused && killed_count == '0)
    else $error("failed request reports a slot, reuse or kill count");

  a_reuse_no_kill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && reused |-> killed_count == '0)
    else $error("reuse and kill count in one response");

endmodule

bind priority_slot_pool_allocator pspa_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_ready    (req_ready),
  .rsp_valid    (rsp_valid),
  .rsp_ready    (rsp_ready),
  .status       (status),
  .slot         (slot),
  .reused       (reused),
  .killed_count (killed_count)
);

// ===== tb/priority_slot_pool_allocator_test.sv =====
// self-checking testbench for priority_slot_pool_allocator: random and directed request traffic,
// a slot pool predictor, response checks, APB register programming and read-back
// depends on pspa_pkg and the priority_slot_pool_allocator rtl
module priority_slot_pool_allocator_test;
  import pspa_pkg::*;

  localparam int SLOTS = POOL_SLOTS_DEF;
  localparam logic [9:0] NIL_SLOT = 10'(SLOTS);
  localparam logic [CFG_ADDR_W-1:0] LIFETIME_ADDR = {REG_LIFETIME, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] MAX_CLIENT_ADDR = {REG_MAX_CLIENT, 2'b00};
  localparam int QUIET_LIMIT = 8000;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic                       model;
    logic signed [CLIENT_W-1:0] client;
    logic [TIME_W-1:0]          now;
    logic [LIFE_W-1:0]          life;
    bit                         hold_for_drain;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                reused;
    logic [COUNT_W-1:0]  killed;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [MODE_W-1:0] mode = '0;
  logic model_present = 1'b0;
  logic signed [CLIENT_W-1:0] client_id = '0;
  logic [TIME_W-1:0] now_time = '0;
  logic [LIFE_W-1:0] life_time = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0] slot;
  logic reused;
  logic [COUNT_W-1:0] killed_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  priority_slot_pool_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .mode(mode), .model_present(model_present), .client_id(client_id),
    .now_time(now_time), .life_time(life_time),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .slot(slot), .reused(reused), .killed_count(killed_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted pool
  logic [9:0] link_mem [SLOTS];
  logic [9:0] free_top, busy_top;
  bit high_mem [SLOTS];
  bit attach_mem [SLOTS];
  bit nomodel_mem [SLOTS];
  logic signed [CLIENT_W-1:0] owner_mem [SLOTS];
  logic [TIME_W-1:0] expiry_mem [SLOTS];
  logic [LIFE_W-1:0] lifetime_reg;
  logic [OWNER_W-1:0] max_client_reg;

  request_t request_queue [$];
  grant_t grant_queue [$];
  request_t cur_req;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int issued_count = 0;
  int results_checked = 0;
  int error_count = 0;
  int reuse_seen = 0;
  int exhausted_seen = 0;
  int bad_client_seen = 0;
  int kill_hits = 0;

  function automatic void pool_reset();
    for (int i = 0; i < SLOTS; i++) begin
      link_mem[i] = 10'(i + 1);
      high_mem[i] = 1'b0;
      attach_mem[i] = 1'b0;
      nomodel_mem[i] = 1'b0;
      owner_mem[i] = '0;
      expiry_mem[i] = '0;
    end
    free_top = '0;
    busy_top = NIL_SLOT;
    lifetime_reg = LIFETIME_RST;
    max_client_reg = MAX_CLIENT_RST;
  endfunction

  function automatic logic [9:0] take_free();
    logic [9:0] s;
    s = free_top;
    free_top = link_mem[s];
    link_mem[s] = busy_top;
    busy_top = s;
    return s;
  endfunction

  function automatic void fresh_slot(logic [9:0] s, logic [TIME_W-1:0] now, bit high,
                                     bit nomodel);
    expiry_mem[s] = now + TIME_W'(lifetime_reg);
    attach_mem[s] = 1'b0;
    owner_mem[s] = '1;
    high_mem[s] = high;
    nomodel_mem[s] = nomodel;
  endfunction

  function automatic logic [STATUS_W-1:0] claim_high(request_t r, output logic [9:0] s,
                                                      output logic reuse);
    logic [9:0] n;
    s = '0;
    reuse = 1'b0;
    if (!r.model) return ST_NO_MODEL;
    if (free_top != NIL_SLOT) begin
      s = take_free();
      fresh_slot(s, r.now, 1'b1, 1'b0);
      return ST_OK;
    end
    n = busy_top;
    for (int k = 0; k < SLOTS && n != NIL_SLOT; k++) begin
      if (!high_mem[n]) begin
        fresh_slot(n, r.now, 1'b1, 1'b0);
        s = n;
        reuse = 1'b1;
        return ST_OK;
      end
      n = link_mem[n];
    end
    return ST_EXHAUSTED;
  endfunction

  function automatic grant_t serve_request(request_t r);
    grant_t g;
    logic [9:0] s;
    logic [9:0] n;
    logic reuse;
    bit client_fits;
    g = '0;
    client_fits = !r.client[CLIENT_W-1] && (r.client[OWNER_W-1:0] <= max_client_reg);
    case (r.mode)
      MODE_ALLOC, MODE_ALLOC_NOMODEL: begin
        if (free_top == NIL_SLOT) begin
          g.status = ST_EXHAUSTED;
        end else if (r.mode == MODE_ALLOC && !r.model) begin
          g.status = ST_NO_MODEL;
        end else begin
          s = take_free();
          fresh_slot(s, r.now, 1'b0, r.mode == MODE_ALLOC_NOMODEL);
          g.slot = s[SLOT_W-1:0];
        end
      end
      MODE_HIGH: begin
        g.status = claim_high(r, s, reuse);
        if (g.status == ST_OK) begin
          g.slot = s[SLOT_W-1:0];
          g.reused = reuse;
        end
      end
      MODE_ATTACH: begin
        if (!client_fits) begin
          g.status = ST_BAD_CLIENT;
        end else begin
          g.status = claim_high(r, s, reuse);
          if (g.status == ST_OK) begin
            attach_mem[s] = 1'b1;
            owner_mem[s] = r.client;
            expiry_mem[s] = r.now + TIME_W'(r.life);
            g.slot = s[SLOT_W-1:0];
            g.reused = reuse;
          end
        end
      end
      MODE_KILL: begin
        if (!client_fits) begin
          g.status = ST_BAD_CLIENT;
        end else begin
          n = busy_top;
          for (int k = 0; k < SLOTS && n != NIL_SLOT; k++) begin
            if (attach_mem[n] && owner_mem[n] == r.client) begin
              expiry_mem[n] = r.now;
              if (g.killed != KILL_MAX) g.killed++;
            end
            n = link_mem[n];
          end
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic request_t make_req(logic [MODE_W-1:0] m, logic model,
                                        logic signed [CLIENT_W-1:0] c, logic [TIME_W-1:0] t,
                                        logic [LIFE_W-1:0] l);
    request_t r;
    r.mode = m;
    r.model = model;
    r.client = c;
    r.now = t;
    r.life = l;
    r.hold_for_drain = 1'b0;
    return r;
  endfunction

  function automatic request_t random_req(int low_pct, int high_pct, int kill_pct);
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r = make_req(MODE_ALLOC, $urandom_range(9) != 0, '0, $urandom, 16'($urandom));
    if ($urandom_range(9) == 0) r.now = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(9) == 0) r.life = $urandom_range(1) ? '1 : '0;
    case ($urandom_range(9))
      0: r.client = 7'($urandom);
      1: r.client = 7'({1'b0, max_client_reg} + 7'd1);
      2: r.client = '1;
      3: r.client = 7'({1'b0, max_client_reg});
      default: r.client = 7'($urandom_range(max_client_reg));
    endcase
    if (pick < low_pct)
      r.mode = $urandom_range(1) ? MODE_ALLOC_NOMODEL : MODE_ALLOC;
    else if (pick < low_pct + high_pct)
      r.mode = $urandom_range(1) ? MODE_ATTACH : MODE_HIGH;
    else if (pick < low_pct + high_pct + kill_pct)
      r.mode = MODE_KILL;
    else
      r.mode = MODE_KILL + 3'($urandom_range(3, 1));
    r.hold_for_drain = ($urandom_range(49) == 0);
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  // request side: accepted transaction is predicted at once
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) grant_queue.push_back(serve_request(cur_req));
      if (!req_valid || req_ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
            !(request_queue[0].hold_for_drain && grant_queue.size() != 0)) begin
          cur_req = request_queue.pop_front();
          issued_count++;
          req_valid <= 1'b1;
          mode <= cur_req.mode;
          model_present <= cur_req.model;
          client_id <= cur_req.client;
          now_time <= cur_req.now;
          life_time <= cur_req.life;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response side
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (grant_queue.size() == 0) begin
          $display("%0t: response with nothing outstanding, status %0d slot %0d", $time,
                   status, slot);
          error_count++;
        end else begin
          want = grant_queue.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("slot", 32'(want.slot), 32'(slot));
          check_field("reused", 32'(want.reused), 32'(reused));
          check_field("killed_count", 32'(want.killed), 32'(killed_count));
          results_checked++;
          if (want.reused) reuse_seen++;
          if (want.status == ST_EXHAUSTED) exhausted_seen++;
          if (want.status == ST_BAD_CLIENT) bad_client_seen++;
          if (want.killed != '0) kill_hits++;
        end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic cfg_read(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read, expected %0d, got %0d", $time, addr, want, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == LIFETIME_ADDR) lifetime_reg = value[LIFE_W-1:0];
    else max_client_reg = value[OWNER_W-1:0];
    cfg_read(addr, value);
  endtask

  task automatic wait_drained();
    while (request_queue.size() != 0 || issued_count != results_checked) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(int count, int low_pct, int high_pct, int kill_pct);
    for (int i = 0; i < count; i++)
      request_queue.push_back(random_req(low_pct, high_pct, kill_pct));
    wait_drained();
  endtask

  initial begin
    request_t r;
    int lows;
    pool_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_read(LIFETIME_ADDR, CFG_DATA_W'(LIFETIME_RST));
    cfg_read(MAX_CLIENT_ADDR, CFG_DATA_W'(MAX_CLIENT_RST));

    // opening checks under reset configuration
    request_queue.push_back(make_req(MODE_ALLOC, 1'b0, '0, 32'd5, 16'd0));
    request_queue.push_back(make_req(MODE_ALLOC, 1'b1, '0, '0, 16'd0));
    request_queue.push_back(make_req(MODE_ALLOC_NOMODEL, 1'b0, '0, '1, '1));
    request_queue.push_back(make_req(MODE_HIGH, 1'b0, '0, 32'd9, 16'd0));
    request_queue.push_back(make_req(MODE_HIGH, 1'b1, '0, '1, 16'd0));
    request_queue.push_back(make_req(MODE_ATTACH, 1'b0, '1, 32'd1, 16'd1));
    request_queue.push_back(make_req(MODE_ATTACH, 1'b1, 7'sd33, 32'd1, 16'd1));
    request_queue.push_back(make_req(MODE_ATTACH, 1'b1, 7'sd32, '1, '1));
    request_queue.push_back(make_req(MODE_ATTACH, 1'b0, 7'sd0, 32'd2, 16'd2));
    request_queue.push_back(make_req(MODE_ATTACH, 1'b1, 7'sd0, '0, '0));
    request_queue.push_back(make_req(MODE_ATTACH, 1'b1, 7'sd32, 32'd77, 16'd1234));
    request_queue.push_back(make_req(MODE_KILL, 1'b1, 7'sh40, 32'd3, 16'd0));
    request_queue.push_back(make_req(MODE_KILL, 1'b1, 7'sd63, 32'd3, 16'd0));
    request_queue.push_back(make_req(MODE_KILL, 1'b1, 7'sd33, 32'd3, 16'd0));
    r = make_req(MODE_KILL, 1'b1, 7'sd32, 32'hDEAD_BEEF, 16'd0);
    r.hold_for_drain = 1'b1;
    request_queue.push_back(r);
    request_queue.push_back(make_req(MODE_KILL, 1'b0, 7'sd0, '1, '1));
    request_queue.push_back(make_req(MODE_KILL, 1'b1, 7'sd7, 32'd4, 16'd0));
    for (int m = 1; m <= 3; m++)
      request_queue.push_back(make_req(MODE_KILL + 3'(m), 1'b1, 7'($urandom), $urandom,
                                       16'($urandom)));
    wait_drained();

    sender_idle_pct <= 0;
    receiver_stall_pct <= 0;
    program_reg(LIFETIME_ADDR, 32'd0);
    program_reg(MAX_CLIENT_ADDR, 32'd63);
    run_random(300, 60, 20, 12);

    sender_idle_pct <= 53;
    receiver_stall_pct <= 0;
    program_reg(LIFETIME_ADDR, 32'd65535);
    program_reg(MAX_CLIENT_ADDR, 32'd0);
    run_random(300, 55, 25, 12);

    sender_idle_pct <= 0;
    receiver_stall_pct <= 53;
    program_reg(LIFETIME_ADDR, 32'($urandom_range(65535)));
    program_reg(MAX_CLIENT_ADDR, 32'($urandom_range(62, 1)));
    run_random(300, 30, 45, 15);

    sender_idle_pct <= 24;
    receiver_stall_pct <= 24;
    program_reg(LIFETIME_ADDR, 32'd750);
    program_reg(MAX_CLIENT_ADDR, 32'd32);
    run_random(250, 20, 60, 12);

    // turn every remaining slot high priority so reuse runs dry
    sender_idle_pct <= 0;
    receiver_stall_pct <= 0;
    forever begin
      lows = 0;
      foreach (high_mem[i]) if (!high_mem[i]) lows++;
      if (free_top == NIL_SLOT && lows == 0) break;
      for (int j = 0; j < 64; j++)
        request_queue.push_back(make_req(j % 2 ? MODE_ATTACH : MODE_HIGH, 1'b1,
                                         7'($urandom_range(max_client_reg)), $urandom,
                                         16'($urandom)));
      wait_drained();
    end

    // full pool with no low-priority slot left
    request_queue.push_back(make_req(MODE_ALLOC, 1'b1, '0, $urandom, 16'd0));
    request_queue.push_back(make_req(MODE_ALLOC, 1'b0, '0, $urandom, 16'd0));
    request_queue.push_back(make_req(MODE_ALLOC_NOMODEL, 1'b0, '0, $urandom, 16'd0));
    request_queue.push_back(make_req(MODE_HIGH, 1'b1, '0, $urandom, 16'd0));
    request_queue.push_back(make_req(MODE_HIGH, 1'b0, '0, $urandom, 16'd0));
    request_queue.push_back(make_req(MODE_ATTACH, 1'b0, '1, $urandom, 16'd0));
    request_queue.push_back(make_req(MODE_ATTACH, 1'b1, 7'sd0, $urandom, 16'd5));
    request_queue.push_back(make_req(MODE_KILL, 1'b1, 7'sd0, $urandom, 16'd0));
    wait_drained();
    repeat (16) @(posedge clk);

    $display("run covered %0d requests and %0d checked responses over four idle mixes",
             issued_count, results_checked);
    $display("reuses %0d, pool exhausted %0d, bad client %0d, kills that hit %0d",
             reuse_seen, exhausted_seen, bad_client_seen, kill_hits);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
